@@ src/lpdr_pkg.sv @@
`timescale 1ns / 1ps
// lpdr_pkg: shared types and constants for the lidar point decimate and ring binner.
// No dependencies.
package lpdr_pkg;

    localparam int WIDTH_FIELDS  = 10;
    localparam int WIDTH_BITS    = 5;
    localparam int RING_CFG_BITS = WIDTH_FIELDS * WIDTH_BITS;
    localparam int RADIUS_M_BITS = 9;                       // up to 10 * 31 m
    localparam int RAD_SQ_BITS   = 2 * (RADIUS_M_BITS + 8); // squared radius, 1/65536 m^2
    localparam int RING_IDX_BITS = 4;
    localparam int KEEP_BITS     = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = RING_CFG_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_KEEP_EVERY  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_Z_LOW       = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_Z_HIGH      = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RING_WIDTHS = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RING_COUNT  = 3'd4;

    localparam logic [KEEP_BITS-1:0]     KEEP_EVERY_RST  = 8'd1;
    localparam int                       Z_LOW_RST       = -205;
    localparam int                       Z_HIGH_RST      = 512;
    localparam logic [RING_CFG_BITS-1:0] RING_WIDTHS_RST = 50'd108923695762530;
    localparam logic [RING_IDX_BITS-1:0] RING_COUNT_RST  = 4'd10;

    typedef struct packed {
        logic                     valid;
        logic                     kept;
        logic                     found;
        logic [RING_IDX_BITS-1:0] idx;
        logic                     frame_end;
        logic [RADIUS_M_BITS-1:0] inner_m;
        logic [RAD_SQ_BITS-1:0]   in_sq;
    } t_ring_ctl;

endpackage

@@ src/lpdr_front.sv @@
`timescale 1ns / 1ps
// lpdr_front: decimation counter, height window and squared range (three stages).
// Depends on lpdr_pkg.
module lpdr_front import lpdr_pkg::*; #(
    parameter int COORD_BITS = 17,
    parameter int D2_BITS    = 2 * COORD_BITS + 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS-1:0] i_pos_x,
    input  logic signed [COORD_BITS-1:0] i_pos_y,
    input  logic signed [COORD_BITS-1:0] i_pos_z,
    input  logic                         i_frame_end,
    input  logic [KEEP_BITS-1:0]         i_keep_every,
    input  logic signed [COORD_BITS-1:0] i_z_low,
    input  logic signed [COORD_BITS-1:0] i_z_high,
    output logic signed [COORD_BITS-1:0] o_x,
    output logic signed [COORD_BITS-1:0] o_y,
    output logic signed [COORD_BITS-1:0] o_z,
    output logic [D2_BITS-1:0]           o_d2,
    output t_ring_ctl                    o_ctl
);

    logic [KEEP_BITS-1:0]   r_fpos;
    logic [KEEP_BITS:0]     n_fpos_inc;
    logic [KEEP_BITS:0]     n_factor;
    logic [KEEP_BITS-1:0]   n_fpos;
    logic                   n_kept;
    logic [COORD_BITS-1:0]  n_ax, n_ay, n_az;
    logic                   accept;

    // stage 1
    logic                         r_v1, r_k1, r_fe1;
    logic signed [COORD_BITS-1:0] r_x1, r_y1, r_z1;
    logic [COORD_BITS-1:0]        r_ax, r_ay, r_az;
    // stage 2
    logic                         r_v2, r_k2, r_fe2;
    logic signed [COORD_BITS-1:0] r_x2, r_y2, r_z2;
    logic [2*COORD_BITS-1:0]      r_sx, r_sy, r_sz;
    // stage 3
    logic                         r_v3, r_k3, r_fe3;
    logic signed [COORD_BITS-1:0] r_x3, r_y3, r_z3;
    logic [D2_BITS-1:0]           r_d2;

    assign accept = i_valid && i_en;

    always_comb begin
        n_fpos_inc = {1'b0, r_fpos} + 1'b1;
        n_factor   = (i_keep_every == '0) ? (KEEP_BITS+1)'(1) : {1'b0, i_keep_every};
        n_fpos     = (n_fpos_inc >= n_factor || i_frame_end) ? '0 : n_fpos_inc[KEEP_BITS-1:0];
        n_kept     = (r_fpos == '0) && (i_pos_z >= i_z_low) && (i_pos_z <= i_z_high);
        n_ax       = i_pos_x[COORD_BITS-1] ? (~i_pos_x + 1'b1) : i_pos_x;
        n_ay       = i_pos_y[COORD_BITS-1] ? (~i_pos_y + 1'b1) : i_pos_y;
        n_az       = i_pos_z[COORD_BITS-1] ? (~i_pos_z + 1'b1) : i_pos_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fpos <= '0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
        end else begin
            if (accept) begin
                r_fpos <= n_fpos;
            end
            if (i_en) begin
                r_v1 <= i_valid;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_k1  <= n_kept;
            r_fe1 <= i_frame_end;
            r_x1  <= i_pos_x;
            r_y1  <= i_pos_y;
            r_z1  <= i_pos_z;
            r_ax  <= n_ax;
            r_ay  <= n_ay;
            r_az  <= n_az;

            r_k2  <= r_k1;
            r_fe2 <= r_fe1;
            r_x2  <= r_x1;
            r_y2  <= r_y1;
            r_z2  <= r_z1;
            r_sx  <= r_ax * r_ax;
            r_sy  <= r_ay * r_ay;
            r_sz  <= r_az * r_az;

            r_k3  <= r_k2;
            r_fe3 <= r_fe2;
            r_x3  <= r_x2;
            r_y3  <= r_y2;
            r_z3  <= r_z2;
            r_d2  <= D2_BITS'(r_sx) + D2_BITS'(r_sy) + D2_BITS'(r_sz);
        end
    end

    always_comb begin
        o_x             = r_x3;
        o_y             = r_y3;
        o_z             = r_z3;
        o_d2            = r_d2;
        o_ctl.valid     = r_v3;
        o_ctl.kept      = r_k3;
        o_ctl.found     = 1'b0;
        o_ctl.idx       = '0;
        o_ctl.frame_end = r_fe3;
        o_ctl.inner_m   = '0;
        o_ctl.in_sq     = '0;
    end

endmodule

@@ src/lpdr_ring_cell.sv @@
`timescale 1ns / 1ps
// lpdr_ring_cell: one ring of the search chain; tests its shell and passes the beat on.
// Depends on lpdr_pkg.
module lpdr_ring_cell import lpdr_pkg::*; #(
    parameter int COORD_BITS = 17,
    parameter int D2_BITS    = 2 * COORD_BITS + 2,
    parameter int CELL_IDX   = 0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic [WIDTH_BITS-1:0]        i_width,
    input  logic [RING_IDX_BITS-1:0]     i_ring_count,
    input  logic signed [COORD_BITS-1:0] i_x,
    input  logic signed [COORD_BITS-1:0] i_y,
    input  logic signed [COORD_BITS-1:0] i_z,
    input  logic [D2_BITS-1:0]           i_d2,
    input  t_ring_ctl                    i_ctl,
    output logic signed [COORD_BITS-1:0] o_x,
    output logic signed [COORD_BITS-1:0] o_y,
    output logic signed [COORD_BITS-1:0] o_z,
    output logic [D2_BITS-1:0]           o_d2,
    output t_ring_ctl                    o_ctl
);

    localparam int CMP_BITS = (D2_BITS > RAD_SQ_BITS) ? D2_BITS : RAD_SQ_BITS;

    logic [RADIUS_M_BITS-1:0]   outer_m;
    logic [2*RADIUS_M_BITS-1:0] outer_m_sq;
    logic [RAD_SQ_BITS-1:0]     out_sq;
    logic [CMP_BITS-1:0]        d2_ext;
    logic                       active;
    logic                       hit;
    t_ring_ctl                  n_ctl;

    t_ring_ctl                    r_ctl;
    logic signed [COORD_BITS-1:0] r_x, r_y, r_z;
    logic [D2_BITS-1:0]           r_d2;

    always_comb begin
        outer_m    = i_ctl.inner_m + RADIUS_M_BITS'(i_width);
        outer_m_sq = outer_m * outer_m;
        out_sq     = {outer_m_sq, 16'b0};
        d2_ext     = CMP_BITS'(i_d2);
        active     = RING_IDX_BITS'(CELL_IDX) < i_ring_count;
        hit        = i_ctl.kept && !i_ctl.found && active
                     && (d2_ext > CMP_BITS'(i_ctl.in_sq))
                     && (d2_ext <= CMP_BITS'(out_sq));
        n_ctl         = i_ctl;
        n_ctl.inner_m = outer_m;
        n_ctl.in_sq   = out_sq;
        if (hit) begin
            n_ctl.found = 1'b1;
            n_ctl.idx   = RING_IDX_BITS'(CELL_IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x  <= i_x;
            r_y  <= i_y;
            r_z  <= i_z;
            r_d2 <= i_d2;
        end
    end

    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;
    assign o_d2  = r_d2;
    assign o_ctl = r_ctl;

endmodule

@@ src/lidar_point_decimate_and_ring_binner_unit.sv @@
`timescale 1ns / 1ps
// lidar_point_decimate_and_ring_binner_unit: top level, config registers and the ring chain.
// Depends on lpdr_pkg, lpdr_front, lpdr_ring_cell.
//
// Usage:
//   Input channel (i_valid / o_stall) takes one point per beat: x, y, z in
//   1/256 m and a frame-end mark. Output channel (o_valid / i_stall) gives one
//   result beat per point, in order: the coordinates, kept, in_ring,
//   ring_index and the frame-end copy.
//   The path is three front stages (window and
//   decimation, squares, range sum) then one cell per ring.
//   Throughput is one point per cycle unless the receiver stalls; the chain moves as one.
//   When the receiver stalls a waiting result, the chain holds and o_stall
//   is raised in the same cycle; nothing is dropped.
//   Configuration is a write port (i_cfg_we, i_cfg_idx, i_cfg_data); the user
//   must write it only while the block is empty, which the block does not enforce.
//   Reset (synchronous, active low) empties the chain, clears the frame
//   position and loads the register defaults.
module lidar_point_decimate_and_ring_binner_unit import lpdr_pkg::*; #(
    parameter int MAX_RINGS  = 10,
    parameter int COORD_BITS = 17
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_BITS-1:0] i_pos_x,
    input  logic signed [COORD_BITS-1:0] i_pos_y,
    input  logic signed [COORD_BITS-1:0] i_pos_z,
    input  logic                         i_frame_end,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [COORD_BITS-1:0] o_out_x,
    output logic signed [COORD_BITS-1:0] o_out_y,
    output logic signed [COORD_BITS-1:0] o_out_z,
    output logic                         o_kept,
    output logic                         o_in_ring,
    output logic [RING_IDX_BITS-1:0]     o_ring_index,
    output logic                         o_out_frame_end,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0]     i_cfg_data
);

    localparam int D2_BITS = 2 * COORD_BITS + 2;

    logic [KEEP_BITS-1:0]         r_keep_every;
    logic signed [COORD_BITS-1:0] r_z_low;
    logic signed [COORD_BITS-1:0] r_z_high;
    logic [RING_CFG_BITS-1:0]     r_ring_widths;
    logic [RING_IDX_BITS-1:0]     r_ring_count;

    logic                         chain_en;
    logic signed [COORD_BITS-1:0] w_x [0:MAX_RINGS];
    logic signed [COORD_BITS-1:0] w_y [0:MAX_RINGS];
    logic signed [COORD_BITS-1:0] w_z [0:MAX_RINGS];
    logic [D2_BITS-1:0]           w_d2 [0:MAX_RINGS];
    t_ring_ctl                    w_ctl [0:MAX_RINGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_every  <= KEEP_EVERY_RST;
            r_z_low       <= COORD_BITS'(Z_LOW_RST);
            r_z_high      <= COORD_BITS'(Z_HIGH_RST);
            r_ring_widths <= RING_WIDTHS_RST;
            r_ring_count  <= RING_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KEEP_EVERY:  r_keep_every  <= i_cfg_data[KEEP_BITS-1:0];
                CFG_Z_LOW:       r_z_low       <= i_cfg_data[COORD_BITS-1:0];
                CFG_Z_HIGH:      r_z_high      <= i_cfg_data[COORD_BITS-1:0];
                CFG_RING_WIDTHS: r_ring_widths <= i_cfg_data[RING_CFG_BITS-1:0];
                CFG_RING_COUNT:  r_ring_count  <= i_cfg_data[RING_IDX_BITS-1:0];
                default: ;
            endcase
        end
    end

    // last cell register is the output register
    assign chain_en = !(w_ctl[MAX_RINGS].valid && i_stall);
    assign o_stall  = !chain_en;

    lpdr_front #(
        .COORD_BITS (COORD_BITS),
        .D2_BITS    (D2_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (chain_en),
        .i_valid      (i_valid),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .i_frame_end  (i_frame_end),
        .i_keep_every (r_keep_every),
        .i_z_low      (r_z_low),
        .i_z_high     (r_z_high),
        .o_x          (w_x[0]),
        .o_y          (w_y[0]),
        .o_z          (w_z[0]),
        .o_d2         (w_d2[0]),
        .o_ctl        (w_ctl[0])
    );

    for (genvar j = 0; j < MAX_RINGS; j++) begin : g_cell
        logic [WIDTH_BITS-1:0] width;
        if (j < WIDTH_FIELDS) begin : g_cfg
            assign width = r_ring_widths[WIDTH_BITS*j +: WIDTH_BITS];
        end else begin : g_zero
            assign width = '0;
        end

        lpdr_ring_cell #(
            .COORD_BITS (COORD_BITS),
            .D2_BITS    (D2_BITS),
            .CELL_IDX   (j)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_en         (chain_en),
            .i_width      (width),
            .i_ring_count (r_ring_count),
            .i_x          (w_x[j]),
            .i_y          (w_y[j]),
            .i_z          (w_z[j]),
            .i_d2         (w_d2[j]),
            .i_ctl        (w_ctl[j]),
            .o_x          (w_x[j+1]),
            .o_y          (w_y[j+1]),
            .o_z          (w_z[j+1]),
            .o_d2         (w_d2[j+1]),
            .o_ctl        (w_ctl[j+1])
        );
    end

    assign o_valid         = w_ctl[MAX_RINGS].valid;
    assign o_out_x         = w_x[MAX_RINGS];
    assign o_out_y         = w_y[MAX_RINGS];
    assign o_out_z         = w_z[MAX_RINGS];
    assign o_kept          = w_ctl[MAX_RINGS].kept;
    assign o_in_ring       = w_ctl[MAX_RINGS].found;
    assign o_ring_index    = w_ctl[MAX_RINGS].found ? w_ctl[MAX_RINGS].idx : '0;
    assign o_out_frame_end = w_ctl[MAX_RINGS].frame_end;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking bench for lidar_point_decimate_and_ring_binner_unit.
// Depends on lpdr_pkg and the unit; predicts every result beat and compares in order.
module tb;
    import lpdr_pkg::*;

    localparam int COORD_BITS     = 17;
    localparam int MAX_RINGS      = 10;
    localparam int LATENCY        = 3 + MAX_RINGS;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASES  = 11;
    localparam int PHASE_POINTS   = 150;
    localparam int COORD_MIN      = -65536;
    localparam int COORD_MAX      = 65535;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct {
        t_coord                   x;
        t_coord                   y;
        t_coord                   z;
        logic                     kept;
        logic                     in_ring;
        logic [RING_IDX_BITS-1:0] idx;
        logic                     fe;
    } t_point_result;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    t_coord                   i_pos_x = '0;
    t_coord                   i_pos_y = '0;
    t_coord                   i_pos_z = '0;
    logic                     i_frame_end = 1'b0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    t_coord                   o_out_x;
    t_coord                   o_out_y;
    t_coord                   o_out_z;
    logic                     o_kept;
    logic                     o_in_ring;
    logic [RING_IDX_BITS-1:0] o_ring_index;
    logic                     o_out_frame_end;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx = CFG_KEEP_EVERY;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    // shadow of the register file and decimation position
    logic [KEEP_BITS-1:0]     keep_reg = KEEP_EVERY_RST;
    t_coord                   zlow_reg = COORD_BITS'(Z_LOW_RST);
    t_coord                   zhigh_reg = COORD_BITS'(Z_HIGH_RST);
    logic [RING_CFG_BITS-1:0] widths_reg = RING_WIDTHS_RST;
    logic [RING_IDX_BITS-1:0] ring_count_reg = RING_COUNT_RST;
    logic [KEEP_BITS-1:0]     frame_pos = '0;

    t_point_result pending_bins[$];
    int            mismatches = 0;
    int            idle_cycles = 0;
    int            stall_left = 0;
    bit            tx_throttle = 1'b0;
    bit            rx_throttle = 1'b0;

    lidar_point_decimate_and_ring_binner_unit #(
        .MAX_RINGS (MAX_RINGS),
        .COORD_BITS(COORD_BITS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_frame_end    (i_frame_end),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_x        (o_out_x),
        .o_out_y        (o_out_y),
        .o_out_z        (o_out_z),
        .o_kept         (o_kept),
        .o_in_ring      (o_in_ring),
        .o_ring_index   (o_ring_index),
        .o_out_frame_end(o_out_frame_end),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int rand_in(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic int clip_coord(input int v);
        if (v < COORD_MIN) return COORD_MIN;
        if (v > COORD_MAX) return COORD_MAX;
        return v;
    endfunction

    // decimation, height window and ring search; advances the frame position
    function automatic t_point_result bin_point(input t_coord x, input t_coord y,
                                                input t_coord z, input logic fe);
        t_point_result res;
        longint        sx, sy, sz, d2, inner, outer, in_sq, out_sq;
        int            factor, count, nxt;
        sx = x;
        sy = y;
        sz = z;
        res.x = x;
        res.y = y;
        res.z = z;
        res.fe = fe;
        res.in_ring = 1'b0;
        res.idx = '0;
        factor = (keep_reg == 0) ? 1 : keep_reg;
        res.kept = (frame_pos == 0) && (z >= zlow_reg) && (z <= zhigh_reg);
        if (res.kept) begin
            d2 = sx * sx + sy * sy + sz * sz;
            count = (ring_count_reg > MAX_RINGS) ? MAX_RINGS : ring_count_reg;
            inner = 0;
            for (int j = 0; j < count && !res.in_ring; j++) begin
                outer = inner + widths_reg[WIDTH_BITS*j +: WIDTH_BITS];
                in_sq = (inner * 256) * (inner * 256);
                out_sq = (outer * 256) * (outer * 256);
                if (d2 > in_sq && d2 <= out_sq) begin
                    res.in_ring = 1'b1;
                    res.idx = j[RING_IDX_BITS-1:0];
                end
                inner = outer;
            end
        end
        nxt = frame_pos + 1;
        if (nxt >= factor || fe) nxt = 0;
        frame_pos = nxt[KEEP_BITS-1:0];
        return res;
    endfunction

    task automatic cmp_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_point_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_bins.size() == 0) begin
                $error("result beat with no point outstanding");
                mismatches++;
            end else begin
                want = pending_bins.pop_front();
                cmp_field("out_x", want.x, o_out_x);
                cmp_field("out_y", want.y, o_out_y);
                cmp_field("out_z", want.z, o_out_z);
                cmp_field("kept", want.kept, o_kept);
                cmp_field("in_ring", want.in_ring, o_in_ring);
                cmp_field("ring_index", want.idx, o_ring_index);
                cmp_field("out_frame_end", want.fe, o_out_frame_end);
            end
        end
    end

    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if (rx_throttle && $urandom_range(0, 99) < 20) begin
            stall_left <= pick_gap();
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_point(input int x, input int y, input int z, input bit fe);
        int            gap;
        t_point_result exp_res;
        gap = tx_throttle ? pick_gap() : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pos_x <= x[COORD_BITS-1:0];
        i_pos_y <= y[COORD_BITS-1:0];
        i_pos_z <= z[COORD_BITS-1:0];
        i_frame_end <= fe;
        do @(posedge i_clk); while (o_stall);
        exp_res = bin_point(x[COORD_BITS-1:0], y[COORD_BITS-1:0],
                            z[COORD_BITS-1:0], fe);
        pending_bins.insert(pending_bins.size(), exp_res);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_bins.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic configure(input int keep, input int zlo, input int zhi,
                             input logic [RING_CFG_BITS-1:0] widths, input int rings);
        logic [CFG_IDX_BITS-1:0]  regs [5];
        logic [CFG_DATA_BITS-1:0] vals [5];
        drain_results();
        regs = '{CFG_KEEP_EVERY, CFG_Z_LOW, CFG_Z_HIGH, CFG_RING_WIDTHS, CFG_RING_COUNT};
        vals[0] = CFG_DATA_BITS'(keep[KEEP_BITS-1:0]);
        vals[1] = CFG_DATA_BITS'(zlo[COORD_BITS-1:0]);
        vals[2] = CFG_DATA_BITS'(zhi[COORD_BITS-1:0]);
        vals[3] = CFG_DATA_BITS'(widths);
        vals[4] = CFG_DATA_BITS'(rings[RING_IDX_BITS-1:0]);
        for (int i = 0; i < 5; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= regs[i];
            i_cfg_data <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        keep_reg = keep[KEEP_BITS-1:0];
        zlow_reg = zlo[COORD_BITS-1:0];
        zhigh_reg = zhi[COORD_BITS-1:0];
        widths_reg = widths;
        ring_count_reg = rings[RING_IDX_BITS-1:0];
    endtask

    // defaults: rings total 28 m, window -205..512
    task automatic test_reset_defaults();
        send_point(0, 0, 0, 1'b0);
        send_point(512, 0, 0, 1'b0);
        send_point(513, 0, 0, 1'b0);
        send_point(0, 0, 512, 1'b0);
        send_point(0, 0, -205, 1'b0);
        send_point(0, 0, 513, 1'b0);
        send_point(0, 0, -206, 1'b0);
        send_point(7168, 0, 0, 1'b0);
        send_point(0, -7169, 0, 1'b0);
        send_point(COORD_MIN, COORD_MIN, 0, 1'b0);
        send_point(COORD_MAX, COORD_MAX, 0, 1'b1);
    endtask

    task automatic test_decimation();
        configure(3, COORD_MIN, COORD_MAX, RING_WIDTHS_RST, 10);
        for (int k = 0; k < 6; k++) send_point(256 * k + 100, -200, 50, k == 3);
        configure(0, COORD_MIN, COORD_MAX, RING_WIDTHS_RST, 10);
        send_point(-300, 400, 0, 1'b0);
        send_point(300, -400, 0, 1'b0);
    endtask

    task automatic test_window_and_rings();
        configure(1, 100, -100, RING_WIDTHS_RST, 10);
        send_point(0, 0, 0, 1'b0);
        send_point(0, 0, 100, 1'b0);
        configure(1, COORD_MIN, COORD_MAX, RING_WIDTHS_RST, 0);
        send_point(300, 0, 0, 1'b0);
        configure(1, COORD_MIN, COORD_MAX, {{8{5'd31}}, 10'd0}, 15);
        send_point(1, 0, 0, 1'b0);
        send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
        send_point(COORD_MIN, 0, 0, 1'b1);
    endtask

    task automatic send_random_point();
        int r, total, span, count, x, y, z, zl, zh, lo, hi, j, outer;
        zl = zlow_reg;
        zh = zhigh_reg;
        count = (ring_count_reg > MAX_RINGS) ? MAX_RINGS : ring_count_reg;
        total = 0;
        for (int k = 0; k < count; k++) total += widths_reg[WIDTH_BITS*k +: WIDTH_BITS];
        span = total * 256 + 256;
        if (span > COORD_MAX) span = COORD_MAX;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            x = rand_in(-span, span);
            y = rand_in(-span, span);
            lo = (zl - 4 > -span) ? zl - 4 : -span;
            hi = (zh + 4 < span) ? zh + 4 : span;
            z = (lo <= hi) ? clip_coord(rand_in(lo, hi)) : clip_coord(zl);
        end else if (r < 75) begin
            x = rand_in(COORD_MIN, COORD_MAX);
            y = rand_in(COORD_MIN, COORD_MAX);
            z = rand_in(COORD_MIN, COORD_MAX);
        end else if (r < 92) begin
            j = (count == 0) ? 0 : $urandom_range(0, count - 1);
            outer = 0;
            for (int k = 0; k <= j; k++) outer += widths_reg[WIDTH_BITS*k +: WIDTH_BITS];
            x = clip_coord(outer * 256 + int'($urandom_range(0, 2)) - 1);
            if ($urandom_range(0, 1)) x = -x;
            y = 0;
            if ($urandom_range(0, 1)) begin
                y = x;
                x = 0;
            end
            z = (zl > 0) ? zl : ((zh < 0) ? zh : 0);
        end else begin
            x = rand_in(-300, 300);
            y = rand_in(-300, 300);
            z = rand_in(-300, 300);
        end
        send_point(x, y, z, $urandom_range(0, 9) == 0);
    endtask

    task automatic test_random_stream();
        int                       keep, zlo, zhi, rings, r;
        logic [RING_CFG_BITS-1:0] widths;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            r = $urandom_range(0, 99);
            keep = (r < 40) ? 1 : (r < 70) ? $urandom_range(2, 5) : (r < 80) ? 0 :
                   (r < 90) ? 255 : $urandom_range(1, 255);
            r = $urandom_range(0, 99);
            if (r < 15) begin
                zlo = COORD_MIN;
                zhi = COORD_MAX;
            end else if (r < 22) begin
                zlo = rand_in(1, 3000);
                zhi = rand_in(-3000, 0);
            end else begin
                zlo = rand_in(-3000, 0);
                zhi = rand_in(0, 3000);
            end
            if ($urandom_range(0, 2) == 0) begin
                widths = RING_CFG_BITS'({$urandom, $urandom});
            end else begin
                for (int k = 0; k < WIDTH_FIELDS; k++)
                    widths[WIDTH_BITS*k +: WIDTH_BITS] = WIDTH_BITS'($urandom_range(0, 3));
            end
            rings = $urandom_range(0, 15);
            case (p)
                0: begin
                    keep = 255;
                    zlo = COORD_MIN;
                    zhi = COORD_MAX;
                    widths = '1;
                    rings = 15;
                end
                1: begin
                    keep = 0;
                    zlo = COORD_MIN;
                    zhi = COORD_MAX;
                    widths = '0;
                    rings = 10;
                end
                2: begin
                    keep = 1;
                    zlo = COORD_MAX;
                    zhi = COORD_MIN;
                end
                3: begin
                    keep = 1;
                    zlo = COORD_MIN;
                    zhi = COORD_MAX;
                    rings = 10;
                end
                default: ;
            endcase
            configure(keep, zlo, zhi, widths, rings);
            tx_throttle = (p % 4 != 0);
            rx_throttle = (p % 4 != 0) && (p % 4 != 3);
            for (int i = 0; i < PHASE_POINTS; i++) begin
                if (p == 5 && i == PHASE_POINTS / 2) drain_results();
                send_random_point();
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        tx_throttle = 1'b1;
        rx_throttle = 1'b1;
        test_reset_defaults();
        test_decimation();
        test_window_and_rings();
        test_random_stream();
        drain_results();
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
